// File: src/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

   localparam logic [7:0]  LEAD_2B  = 8'hC0;
   localparam logic [7:0]  LEAD_3B  = 8'hE0;
   localparam logic [7:0]  LEAD_4B  = 8'hF0;
   localparam logic [7:0]  LEAD_BAD = 8'hF8;
   localparam logic [1:0]  CONT_TAG = 2'b10;

   localparam logic [2:0]  LEN_NONE = 3'd0;
   localparam logic [2:0]  LEN_2B   = 3'd2;
   localparam logic [2:0]  LEN_3B   = 3'd3;
   localparam logic [2:0]  LEN_4B   = 3'd4;

   localparam logic [20:0] MIN_2B  = 21'h00080;
   localparam logic [20:0] MIN_3B  = 21'h00800;
   localparam logic [20:0] MIN_4B  = 21'h10000;
   localparam logic [20:0] SURR_LO = 21'h0D800;
   localparam logic [20:0] SURR_HI = 21'h0DFFF;
   localparam logic [20:0] CP_MAX  = 21'h10FFFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef struct packed {
      logic [20:0] code_point;
      logic        invalid;
      logic        finished;
   } rslt_type;

   // trailing word that closes a buffer after an invalid result
   localparam rslt_type END_MARK = '{code_point: 21'd0, invalid: 1'b1, finished: 1'b1};

   typedef struct packed {
      logic [1:0] count;
      rslt_type   first;
   } dec_out_type;

endpackage

// File: src/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 byte stream to code point decoder.
// Input channel (req_): one byte per word in req_tdata, req_tlast on the final
// byte of a buffer. Result channel (rsp_): one decoded code point per word in
// rsp_tdata, rsp_tuser set when the sequence is invalid, rsp_tlast when the
// word ends the buffer. An invalid word at a buffer end is followed by one
// more word with code point 0, invalid and last set.
// A byte is decoded in the cycle it is accepted and its results are written
// into a four-word result queue, from which rsp_ is driven. Bytes are taken
// one per cycle while the queue has room for two words; the queue drains one
// word per cycle while rsp_tready is high, so a byte that yields two words
// takes two queue slots and two output words.
// When rsp_tready is low the queue fills and req_tready drops once fewer than
// two slots are free; no word is lost or repeated.
// Synchronous reset closes any open sequence, ends skipping and empties the
// queue; the first byte after reset starts a new buffer.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic        rsp_tuser,   // [0] invalid
   output logic        rsp_tlast
);
   import utf8d_pkg::*;

   logic        accept;
   dec_out_type dec_out;
   logic [1:0]  push_count;
   logic        room;
   rslt_type    head_word;

   assign req_tready = room;
   assign accept     = req_tvalid && room;
   assign push_count = accept ? dec_out.count : 2'd0;

   utf8d_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .dec_out   (dec_out)
   );

   utf8d_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_word  (dec_out.first),
      .pop        (rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head_word  (head_word)
   );

   assign rsp_tdata = {3'd0, head_word.code_point};
   assign rsp_tuser = head_word.invalid;
   assign rsp_tlast = head_word.finished;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 24'd0))
      else $error("invalid word carries a code point");
   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20:0] <= CP_MAX))
      else $error("code point out of range");
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");
`endif

endmodule

// File: src/utf8d_decode.sv
`timescale 1ns / 1ps

module utf8d_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output utf8d_pkg::dec_out_type dec_out
);
   import utf8d_pkg::*;

   logic [20:0] accum_ff, accum_in;
   logic [2:0]  needed_ff, needed_in;
   logic [2:0]  seen_ff, seen_in;
   logic        cerr_ff, cerr_in;
   logic        skip_ff, skip_in;

   logic [20:0] cont_acc;
   logic        cont_err;
   logic [2:0]  seen_inc;
   logic [20:0] min_cp;
   logic        bad_cp;

   always_comb begin
      cont_acc = {accum_ff[14:0], data_byte[5:0]};
      cont_err = cerr_ff | (data_byte[7:6] != CONT_TAG);
      seen_inc = seen_ff + 3'd1;
      case (needed_ff)
         LEN_2B:  min_cp = MIN_2B;
         LEN_3B:  min_cp = MIN_3B;
         default: min_cp = MIN_4B;
      endcase
      bad_cp = cont_err || (cont_acc < min_cp) ||
               ((cont_acc >= SURR_LO) && (cont_acc <= SURR_HI)) || (cont_acc > CP_MAX);
   end

   always_comb begin
      accum_in  = accum_ff;
      needed_in = needed_ff;
      seen_in   = seen_ff;
      cerr_in   = cerr_ff;
      skip_in   = skip_ff;
      dec_out.count = 2'd0;
      dec_out.first = '{code_point: 21'd0, invalid: 1'b1, finished: 1'b0};
      if (skip_ff) begin
         if (last_byte) begin
            dec_out.count = 2'd1;
            dec_out.first.finished = 1'b1;
            skip_in = 1'b0;
         end
      end else if (needed_ff == LEN_NONE) begin
         if (!data_byte[7]) begin
            dec_out.count = 2'd1;
            dec_out.first = '{code_point: {13'd0, data_byte}, invalid: 1'b0,
                              finished: last_byte};
         end else if ((data_byte < LEAD_2B) || (data_byte >= LEAD_BAD)) begin
            dec_out.count = last_byte ? 2'd2 : 2'd1;
            skip_in = ~last_byte;
         end else if (last_byte) begin
            dec_out.count = 2'd2;
         end else begin
            seen_in = 3'd1;
            cerr_in = 1'b0;
            if (data_byte < LEAD_3B) begin
               needed_in = LEN_2B;
               accum_in  = {16'd0, data_byte[4:0]};
            end else if (data_byte < LEAD_4B) begin
               needed_in = LEN_3B;
               accum_in  = {17'd0, data_byte[3:0]};
            end else begin
               needed_in = LEN_4B;
               accum_in  = {18'd0, data_byte[2:0]};
            end
         end
      end else if (seen_inc < needed_ff) begin
         if (last_byte) begin
            accum_in  = 21'd0;
            needed_in = LEN_NONE;
            seen_in   = 3'd0;
            cerr_in   = 1'b0;
            dec_out.count = 2'd2;
         end else begin
            accum_in = cont_acc;
            seen_in  = seen_inc;
            cerr_in  = cont_err;
         end
      end else begin
         accum_in  = 21'd0;
         needed_in = LEN_NONE;
         seen_in   = 3'd0;
         cerr_in   = 1'b0;
         if (bad_cp) begin
            dec_out.count = last_byte ? 2'd2 : 2'd1;
         end else begin
            dec_out.count = 2'd1;
            dec_out.first = '{code_point: cont_acc, invalid: 1'b0, finished: last_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= 21'd0;
         needed_ff <= LEN_NONE;
         seen_ff   <= 3'd0;
         cerr_ff   <= 1'b0;
         skip_ff   <= 1'b0;
      end else if (accept) begin
         accum_ff  <= accum_in;
         needed_ff <= needed_in;
         seen_ff   <= seen_in;
         cerr_ff   <= cerr_in;
         skip_ff   <= skip_in;
      end
   end

`ifndef SYNTHESIS
   a_skip_closed: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (needed_ff == LEN_NONE))
      else $error("skipping while a sequence is open");
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      (needed_ff != LEN_NONE) |-> ((seen_ff != 3'd0) && (seen_ff < needed_ff)))
      else $error("byte count outside open sequence");
   a_closed_clean: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == LEN_NONE) |-> ((seen_ff == 3'd0) && (accum_ff == 21'd0) && !cerr_ff))
      else $error("closed sequence left state behind");
   a_len_code: assert property (@(posedge clock) disable iff (reset)
      (needed_ff == LEN_NONE) || (needed_ff == LEN_2B) ||
      (needed_ff == LEN_3B) || (needed_ff == LEN_4B))
      else $error("bad sequence length");
   a_two_end: assert property (@(posedge clock) disable iff (reset)
      (accept && (dec_out.count == 2'd2)) |-> (last_byte && dec_out.first.invalid))
      else $error("second result without invalid buffer end");
`endif

endmodule

// File: src/utf8d_rsp_queue.sv
`timescale 1ns / 1ps

module utf8d_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  utf8d_pkg::rslt_type push_word,
   input  logic                pop,
   output logic                room,
   output logic                head_valid,
   output utf8d_pkg::rslt_type head_word
);
   import utf8d_pkg::*;

   rslt_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ff, wr_in;
   logic [QUEUE_AW-1:0]     rd_ff, rd_in;
   logic [QUEUE_CW-1:0]     count_ff, count_in;
   logic [QUEUE_AW-1:0]     wr_next;
   logic                    do_pop;

   assign wr_next    = wr_ff + QUEUE_AW'(1);
   assign head_valid = (count_ff != '0);
   assign head_word  = entry_ff[rd_ff];
   assign room       = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff + QUEUE_AW'(push_count);
      rd_in    = rd_ff + QUEUE_AW'(do_pop);
      count_in = count_ff + QUEUE_CW'(push_count) - QUEUE_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ff] <= push_word;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= END_MARK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("push without room");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff < QUEUE_CW'(QUEUE_DEPTH)) |-> (QUEUE_AW'(wr_ff - rd_ff) == count_ff[QUEUE_AW-1:0]))
      else $error("queue pointers disagree with count");
`endif

endmodule
